// File: design/aes_pkg.sv
`default_nettype none
package aes_pkg;

  localparam int KEY_STORE_WORDS_DEF = 60;
  localparam int MAX_ROUNDS_DEF      = 14;
  localparam int MIN_ROUNDS          = 10;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_ENCRYPT = 2'd1,
    ACT_DECRYPT = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  localparam logic [31:0] REG_ROUND_COUNT = 32'd0;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

endpackage
`default_nettype wire

// File: design/aes_block_cipher_top.sv
// channel  | valid / stall            | payload
// ---------+--------------------------+-----------------------------------------
// in       | in_valid_i / in_stall_o  | action, key_index, key_word, block_high/low
// out      | out_valid_o / out_stall_i| result_high, result_low
// cfg      | apb psel/penable/pwrite  | round_count at byte address 0
//
// loads are taken back to back; a block runs Nr+1 key steps, each of four
// column reads from the key store's registered read port, with one pass
// of the round unit between steps, then hands over the result; the input
// stays stalled until the block has handed over its result and is idle.
// reset clears control and the round count (10); key store is not cleared.
// a finished result waits in the output register while the next request runs;
// that result then waits, with the input stalled, until the first is taken.
`default_nettype none
module aes_block_cipher_top
  import aes_pkg::*;
#(
  parameter int KEY_STORE_WORDS = KEY_STORE_WORDS_DEF,
  parameter int MAX_ROUNDS      = MAX_ROUNDS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [5:0]  key_index_i,
  input  wire logic [31:0] key_word_i,
  input  wire logic [63:0] block_high_i,
  input  wire logic [63:0] block_low_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      result_high_o,
  output logic [63:0]      result_low_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_KEY  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [3:0]   round_count_q;
  logic [1:0]   state_q, state_d;
  logic [127:0] st_q, st_d;
  logic         dec_q;
  logic [3:0]   nr_q;
  logic [3:0]   rnd_q, rnd_d;
  logic [1:0]   col_q, col_d;
  logic [127:0] acc_q, acc_d;
  logic [31:0]  kw_q;
  logic [31:0]  kstore [KEY_STORE_WORDS];

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_ROUND_COUNT[1:0]) ? {28'd0, round_count_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= 4'(MIN_ROUNDS);
    end else if (psel && penable && pwrite && paddr == REG_ROUND_COUNT[1:0]) begin
      round_count_q <= pwdata[3:0];
    end
  end

  logic in_acc, out_busy;
  assign out_busy   = out_valid_o && out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // saturated round count
  logic [3:0] nr_sat;
  always_comb begin
    if (round_count_q < 4'(MIN_ROUNDS)) nr_sat = 4'(MIN_ROUNDS);
    else if (round_count_q > 4'(MAX_ROUNDS)) nr_sat = 4'(MAX_ROUNDS);
    else nr_sat = round_count_q;
  end

  // key index for current step
  logic [5:0] kidx;
  assign kidx = {rnd_q, col_q};

  // key store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_acc && action_i == ACT_LOAD && 32'(key_index_i) < 32'(KEY_STORE_WORDS))
      kstore[key_index_i] <= key_word_i;
    if (32'(kidx) < 32'(KEY_STORE_WORDS)) begin
      kw_q <= kstore[kidx];
    end else begin
      kw_q <= 32'd0;
    end
  end

  // shared round unit
  logic [7:0] sb [16];
  logic [7:0] sh [16];
  logic [7:0] sbx [16];
  logic [7:0] mx [16];
  logic [127:0] fwd_nomix, fwd_mix, inv_nomix;
  always_comb begin
    for (int i = 0; i < 16; i++) sb[i] = acc_q[127-8*i -: 8];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        sh[r+4*c] = dec_q ? sb[r+4*((c-r+4)&3)] : sb[r+4*((c+r)&3)];
    for (int i = 0; i < 16; i++) sbx[i] = dec_q ? ISBOX[sh[i]] : SBOX[sh[i]];
    for (int i = 0; i < 16; i++) begin
      fwd_nomix[127-8*i -: 8] = sbx[i];
      inv_nomix[127-8*i -: 8] = sbx[i];
    end
    // mixcolumns: encrypt mixes the substituted state, decrypt the raw state (inverse cipher mixes after key add)
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (dec_q)
          mx[4*c+r] = gmul(sb[4*c+r], 4'he) ^ gmul(sb[4*c+((r+1)&3)], 4'hb)
                    ^ gmul(sb[4*c+((r+2)&3)], 4'hd) ^ gmul(sb[4*c+((r+3)&3)], 4'h9);
        else
          mx[4*c+r] = gmul(sbx[4*c+r], 4'h2) ^ gmul(sbx[4*c+((r+1)&3)], 4'h3)
                    ^ sbx[4*c+((r+2)&3)] ^ sbx[4*c+((r+3)&3)];
      end
    for (int i = 0; i < 16; i++) fwd_mix[127-8*i -: 8] = mx[i];
  end

  // for decryption: state after invmix then invshift/invsub
  logic [7:0] dsh [16];
  logic [127:0] inv_mix_sub;
  always_comb begin
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        dsh[r+4*c] = mx[r+4*((c-r+4)&3)];
    for (int i = 0; i < 16; i++) inv_mix_sub[127-8*i -: 8] = ISBOX[dsh[i]];
  end

  // sequencer: step k (0..Nr) xors four key words; between steps the round
  // unit is applied once. keys are indexed by step round for encrypt and
  // by Nr-step for decrypt.
  logic [3:0] step_q, step_d;
  logic [127:0] key_xor;
  logic [1:0]   col_rd_q;
  logic         rd_pend_q;
  always_comb begin
    key_xor = acc_q;
    key_xor[127-32*col_rd_q -: 32] = acc_q[127-32*col_rd_q -: 32] ^ kw_q;
  end

  logic out_load;
  logic [127:0] res_q;
  logic         rv_q;
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    col_d    = col_q;
    rnd_d    = rnd_q;
    acc_d    = acc_q;
    st_d     = st_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (action_i == ACT_ENCRYPT || action_i == ACT_DECRYPT)) begin
          state_d = ST_KEY;
          acc_d   = {block_high_i, block_low_i};
          step_d  = 4'd0;
          col_d   = 2'd0;
          rnd_d   = (action_i == ACT_DECRYPT) ? nr_sat : 4'd0;
        end
      end
      ST_KEY: begin
        if (rd_pend_q) acc_d = key_xor;
        if (col_q != 2'd3 || !rd_pend_q || col_rd_q != 2'd3) begin
          if (col_q != 2'd3) col_d = col_q + 2'd1;
          else col_d = col_q;
        end
        if (rd_pend_q && col_rd_q == 2'd3) begin
          // step finished; apply round unit or finish
          if (step_q == nr_q) begin
            state_d = ST_DONE;
            st_d    = key_xor;
          end else begin
            step_d = step_q + 4'd1;
            col_d  = 2'd0;
            rnd_d  = dec_q ? (nr_q - step_q - 4'd1) : (step_q + 4'd1);
            acc_d  = key_xor;
            st_d   = key_xor;
          end
        end
      end
      ST_DONE: begin
        if (!(rv_q && out_busy)) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // round transform is applied on the registered state at step boundary:
  // acc holds post-key state; round unit output becomes acc for next step
  logic         xform_q;
  logic [127:0] xform_val;
  always_comb begin
    if (dec_q) xform_val = (step_q == 4'd1) ? inv_nomix : inv_mix_sub;
    else       xform_val = (step_q == nr_q) ? fwd_nomix : fwd_mix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= 4'd0;
      col_q     <= 2'd0;
      rnd_q     <= 4'd0;
      rd_pend_q <= 1'b0;
      col_rd_q  <= 2'd0;
      xform_q   <= 1'b0;
      rv_q      <= 1'b0;
      dec_q     <= 1'b0;
      nr_q      <= 4'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      rnd_q   <= rnd_d;
      if (state_q == ST_IDLE && state_d == ST_KEY) begin
        dec_q     <= (action_i == ACT_DECRYPT);
        nr_q      <= nr_sat;
        rd_pend_q <= 1'b0;
        xform_q   <= 1'b0;
        col_q     <= 2'd0;
      end else if (state_q == ST_KEY) begin
        if (xform_q) begin
          // round unit output is loaded into acc, then key reads restart
          xform_q   <= 1'b0;
          rd_pend_q <= 1'b0;
          col_q     <= 2'd0;
        end else if (rd_pend_q && col_rd_q == 2'd3) begin
          xform_q   <= (state_d == ST_KEY);
          rd_pend_q <= 1'b0;
          col_q     <= 2'd0;
        end else begin
          rd_pend_q <= 1'b1;
          col_rd_q  <= col_q;
          col_q     <= col_d;
        end
      end else begin
        rd_pend_q <= 1'b0;
      end
      if (out_load) rv_q <= 1'b1;
      else if (rv_q && !out_stall_i) rv_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_KEY && xform_q) acc_q <= xform_val;
    else acc_q <= acc_d;
    st_q <= st_d;
    if (out_load) res_q <= st_q;
  end

  assign out_valid_o   = rv_q;
  assign result_high_o = res_q[127:64];
  assign result_low_o  = res_q[63:0];

  logic unused;
  assign unused = ^{pwdata[31:4]};

endmodule
`default_nettype wire
